// File: design/grmo_pkg.sv
// shared constants and types for the grid ray march block
package grmo_pkg;

    // largest grid side held by the map
    localparam int MAX_SIDE = 32;

    // field widths
    localparam int SIZE_W  = 6;
    localparam int START_W = 7;
    localparam int DIR_W   = 6;
    localparam int END_W   = 8;

    // row or column index into the map
    localparam int ROW_W = $clog2(MAX_SIDE);

    // working position width: holds a start, and an inside position plus a step
    localparam int POS_W = ($clog2(MAX_SIDE + 32) + 1 > END_W) ?
                           ($clog2(MAX_SIDE + 32) + 1) : END_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b1;

    // reset value of both size registers
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

    // item function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_MARCH = 1'b1;

    // map access request, one row of the map per entry
    typedef struct packed {
        logic                we;
        logic [ROW_W-1:0]    addr;
        logic [MAX_SIDE-1:0] wdata;
    } mem_req_t;

endpackage

// File: design/grmo_ram.sv
// generic single port ram with registered read data
module grmo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: design/grmo_ctrl.sv
// request sequencer: map writes and ray march over the obstacle map
module grmo_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [grmo_pkg::SIZE_W-1:0]         grid_height,
    input  logic [grmo_pkg::SIZE_W-1:0]         grid_width,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic signed [grmo_pkg::START_W-1:0] start_row,
    input  logic signed [grmo_pkg::START_W-1:0] start_col,
    input  logic signed [grmo_pkg::DIR_W-1:0]   dir_row,
    input  logic signed [grmo_pkg::DIR_W-1:0]   dir_col,
    input  logic                                blocked,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [grmo_pkg::END_W-1:0]   end_row,
    output logic signed [grmo_pkg::END_W-1:0]   end_col,
    output grmo_pkg::mem_req_t                  mem_req,
    input  logic [grmo_pkg::MAX_SIDE-1:0]       mem_rdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MARCH = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    localparam int POS_W = grmo_pkg::POS_W;
    localparam int ROW_W = grmo_pkg::ROW_W;
    localparam int DIR_W = grmo_pkg::DIR_W;
    localparam int END_W = grmo_pkg::END_W;

    logic [1:0]                    state_reg, state_next;
    logic                          out_valid_reg, out_valid_next;
    logic [grmo_pkg::MAX_SIDE-1:0] row_valid_reg, row_valid_next;
    logic                          rd_valid_reg;

    logic signed [POS_W-1:0] pos_row_reg, pos_row_next;
    logic signed [POS_W-1:0] pos_col_reg, pos_col_next;
    logic signed [DIR_W-1:0] dir_row_reg, dir_row_next;
    logic signed [DIR_W-1:0] dir_col_reg, dir_col_next;
    logic                    blk_reg, blk_next;
    logic signed [END_W-1:0] end_row_reg, end_row_next;
    logic signed [END_W-1:0] end_col_reg, end_col_next;

    logic signed [POS_W-1:0] side_h, side_w;
    logic signed [POS_W-1:0] start_row_ext, start_col_ext;
    logic signed [POS_W-1:0] next_row, next_col;
    logic                    in_accept;
    logic                    out_free;
    logic                    cur_inside;
    logic                    cur_blocked;
    logic                    zero_step;
    logic                    stop;
    logic [ROW_W-1:0]        cur_row_idx, cur_col_idx;
    logic [grmo_pkg::MAX_SIDE-1:0] row_data, row_mod;

    // effective grid sides, clipped to the map size
    always_comb
    begin
        if (POS_W'(grid_height) > POS_W'(grmo_pkg::MAX_SIDE))
        begin
            side_h = POS_W'(grmo_pkg::MAX_SIDE);
        end
        else
        begin
            side_h = POS_W'(grid_height);
        end
        if (POS_W'(grid_width) > POS_W'(grmo_pkg::MAX_SIDE))
        begin
            side_w = POS_W'(grmo_pkg::MAX_SIDE);
        end
        else
        begin
            side_w = POS_W'(grid_width);
        end
    end

    // handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // sign extended start and next position
    assign start_row_ext = POS_W'(start_row);
    assign start_col_ext = POS_W'(start_col);
    assign next_row      = pos_row_reg + POS_W'(dir_row_reg);
    assign next_col      = pos_col_reg + POS_W'(dir_col_reg);

    // checks on the current position, map row arrives from the ram
    assign cur_row_idx = pos_row_reg[ROW_W-1:0];
    assign cur_col_idx = pos_col_reg[ROW_W-1:0];
    assign cur_inside  = (pos_row_reg >= 0) && (pos_row_reg < side_h) &&
                         (pos_col_reg >= 0) && (pos_col_reg < side_w);
    assign row_data    = rd_valid_reg ? mem_rdata : '0;
    assign cur_blocked = row_data[cur_col_idx];
    assign zero_step   = (dir_row_reg == '0) && (dir_col_reg == '0);
    assign stop        = !cur_inside || cur_blocked || zero_step;

    // row with the written cell replaced
    always_comb
    begin
        row_mod              = row_data;
        row_mod[cur_col_idx] = blk_reg;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        row_valid_next = row_valid_reg;
        pos_row_next   = pos_row_reg;
        pos_col_next   = pos_col_reg;
        dir_row_next   = dir_row_reg;
        dir_col_next   = dir_col_reg;
        blk_next       = blk_reg;
        end_row_next   = end_row_reg;
        end_col_next   = end_col_reg;
        mem_req.we     = 1'b0;
        mem_req.addr   = cur_row_idx;
        mem_req.wdata  = row_mod;

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_req.addr = start_row_ext[ROW_W-1:0];
                if (in_accept)
                begin
                    pos_row_next = start_row_ext;
                    pos_col_next = start_col_ext;
                    dir_row_next = dir_row;
                    dir_col_next = dir_col;
                    blk_next     = blocked;
                    state_next   = (func == grmo_pkg::FUNC_MARCH) ? ST_MARCH : ST_WRITE;
                end
            end
            ST_MARCH:
            begin
                if (stop)
                begin
                    // hold the current row read until the result can leave
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        end_row_next   = pos_row_reg[END_W-1:0];
                        end_col_next   = pos_col_reg[END_W-1:0];
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    // step on and fetch the row of the next position
                    pos_row_next = next_row;
                    pos_col_next = next_col;
                    mem_req.addr = next_row[ROW_W-1:0];
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    mem_req.we     = cur_inside;
                    out_valid_next = 1'b1;
                    end_row_next   = '0;
                    end_col_next   = '0;
                    state_next     = ST_IDLE;
                    if (cur_inside)
                    begin
                        row_valid_next[cur_row_idx] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            row_valid_reg <= row_valid_next;
        end
    end

    // payload registers, row valid flag follows the ram read
    always_ff @(posedge clk)
    begin
        rd_valid_reg <= row_valid_reg[mem_req.addr];
        pos_row_reg  <= pos_row_next;
        pos_col_reg  <= pos_col_next;
        dir_row_reg  <= dir_row_next;
        dir_col_reg  <= dir_col_next;
        blk_reg      <= blk_next;
        end_row_reg  <= end_row_next;
        end_col_reg  <= end_col_next;
    end

    assign out_valid = out_valid_reg;
    assign end_row   = end_row_reg;
    assign end_col   = end_col_reg;

endmodule

// File: design/grid_ray_march_to_obstacle_top.sv
// grid ray march top: size registers, obstacle map ram and sequencer
// write request: taken in idle; the write state then issues the ram write and the result
// and returns to idle, so a new request is taken only after the result is issued
// march request of k steps (k <= 32): the march state steps the ray until it stops,
// one map row read per step on the single ram port, then issues the result and goes idle
// a stalled result holds the sequencer; reset: both sizes 32, cells open via row flags
module grid_ray_march_to_obstacle_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [grmo_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [grmo_pkg::SIZE_W-1:0]             cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    func,
    input  logic signed [grmo_pkg::START_W-1:0]     start_row,
    input  logic signed [grmo_pkg::START_W-1:0]     start_col,
    input  logic signed [grmo_pkg::DIR_W-1:0]       dir_row,
    input  logic signed [grmo_pkg::DIR_W-1:0]       dir_col,
    input  logic                                    blocked,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic signed [grmo_pkg::END_W-1:0]       end_row,
    output logic signed [grmo_pkg::END_W-1:0]       end_col
);

    logic [grmo_pkg::SIZE_W-1:0]   grid_height_reg, grid_height_next;
    logic [grmo_pkg::SIZE_W-1:0]   grid_width_reg, grid_width_next;
    grmo_pkg::mem_req_t            mem_req;
    logic [grmo_pkg::MAX_SIDE-1:0] mem_rdata;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        grid_height_next = grid_height_reg;
        grid_width_next  = grid_width_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                grmo_pkg::REG_GRID_HEIGHT: grid_height_next = cfg_data;
                grmo_pkg::REG_GRID_WIDTH:  grid_width_next  = cfg_data;
                default:                   grid_height_next = grid_height_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_height_reg <= grmo_pkg::SIZE_RESET;
            grid_width_reg  <= grmo_pkg::SIZE_RESET;
        end
        else
        begin
            grid_height_reg <= grid_height_next;
            grid_width_reg  <= grid_width_next;
        end
    end

    // sequencer
    grmo_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .grid_height (grid_height_reg),
        .grid_width  (grid_width_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .start_row   (start_row),
        .start_col   (start_col),
        .dir_row     (dir_row),
        .dir_col     (dir_col),
        .blocked     (blocked),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .end_row     (end_row),
        .end_col     (end_col),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata)
    );

    // obstacle map, one grid row per entry
    grmo_ram #(
        .WIDTH (grmo_pkg::MAX_SIDE),
        .DEPTH (grmo_pkg::MAX_SIDE)
    ) u_map_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for the grid ray march block
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import grmo_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_ITEMS   = 55;

    typedef enum logic [1:0] {REQ_ITEM, REQ_CFG, REQ_DRAIN} grid_req_kind_t;

    // one pending request for the driver: a map item, a size write or a drain point
    typedef struct {
        grid_req_kind_t              kind;
        logic                        f;
        logic signed [START_W-1:0]   sr;
        logic signed [START_W-1:0]   sc;
        logic signed [DIR_W-1:0]     dr;
        logic signed [DIR_W-1:0]     dc;
        logic                        blk;
        logic [CFG_IDX_W-1:0]        idx;
        logic [SIZE_W-1:0]           data;
        int                          gap;
    } grid_req_t;

    typedef struct {
        logic signed [END_W-1:0] row;
        logic signed [END_W-1:0] col;
    } end_cell_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = REG_GRID_HEIGHT;
    logic [SIZE_W-1:0]          cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       func = FUNC_WRITE;
    logic signed [START_W-1:0]  start_row = '0;
    logic signed [START_W-1:0]  start_col = '0;
    logic signed [DIR_W-1:0]    dir_row = '0;
    logic signed [DIR_W-1:0]    dir_col = '0;
    logic                       blocked = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [END_W-1:0]    end_row;
    logic signed [END_W-1:0]    end_col;

    grid_req_t           grid_reqs[$];
    end_cell_t           end_cells_due[$];

    // predictor state: sizes and obstacle bits
    logic [SIZE_W-1:0]   rows_in_use = SIZE_RESET;
    logic [SIZE_W-1:0]   cols_in_use = SIZE_RESET;
    bit [MAX_SIDE-1:0]   cell_map [MAX_SIDE];

    int  fail_count = 0;
    int  in_flight = 0;
    int  gap_left = 0;
    int  settle_cnt = 0;
    int  stall_left = 0;
    int  results_seen = 0;
    int  idle_cycles = 0;
    bit  calm_send = 1'b0;
    bit  calm_recv = 1'b0;

    // sizes as planned by the stimulus generator
    logic [SIZE_W-1:0]   plan_rows = SIZE_RESET;
    logic [SIZE_W-1:0]   plan_cols = SIZE_RESET;

    grid_ray_march_to_obstacle_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .start_row (start_row),
        .start_col (start_col),
        .dir_row   (dir_row),
        .dir_col   (dir_col),
        .blocked   (blocked),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .end_row   (end_row),
        .end_col   (end_col)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // size register value as the grid sees it
    function automatic int clip_side(input logic [SIZE_W-1:0] v);
        return (int'(v) > MAX_SIDE) ? MAX_SIDE : int'(v);
    endfunction

    // apply one accepted item to the map and work out where it ends
    function automatic end_cell_t predict_end_cell(input grid_req_t rq);
        end_cell_t res;
        int h;
        int w;
        int r;
        int c;
        int dr;
        int dc;
        h = clip_side(rows_in_use);
        w = clip_side(cols_in_use);
        r = rq.sr;
        c = rq.sc;
        dr = rq.dr;
        dc = rq.dc;
        res.row = '0;
        res.col = '0;
        if (rq.f == FUNC_WRITE)
        begin
            if (r >= 0 && r < h && c >= 0 && c < w)
                cell_map[r][c] = rq.blk;
            return res;
        end
        // step until outside, blocked or stuck
        for (int n = 0; n <= MAX_SIDE; n++)
        begin
            if (!(r >= 0 && r < h && c >= 0 && c < w))
                break;
            if (cell_map[r][c])
                break;
            if (dr == 0 && dc == 0)
                break;
            r += dr;
            c += dc;
        end
        res.row = END_W'(r);
        res.col = END_W'(c);
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        fail_count++;
    endtask

    // stimulus queue fillers
    task automatic add_item(input logic f, input int sr, input int sc, input int dr,
                            input int dc, input logic blk);
        grid_req_t rq;
        rq.kind = REQ_ITEM;
        rq.f    = f;
        rq.sr   = START_W'(sr);
        rq.sc   = START_W'(sc);
        rq.dr   = DIR_W'(dr);
        rq.dc   = DIR_W'(dc);
        rq.blk  = blk;
        rq.idx  = REG_GRID_HEIGHT;
        rq.data = '0;
        rq.gap  = calm_send ? 0 : $urandom_range(0, 4);
        grid_reqs.push_back(rq);
    endtask

    task automatic add_ctrl(input grid_req_kind_t kind, input logic [CFG_IDX_W-1:0] idx,
                            input logic [SIZE_W-1:0] data);
        grid_req_t rq;
        rq = '{kind: kind, f: FUNC_WRITE, sr: '0, sc: '0, dr: '0, dc: '0, blk: 1'b0,
               idx: idx, data: data, gap: 0};
        grid_reqs.push_back(rq);
    endtask

    // drain, resize, then a burst of mostly in-grid random requests
    task automatic random_phase(input logic [SIZE_W-1:0] h, input logic [SIZE_W-1:0] w);
        int eh;
        int ew;
        int sr;
        int sc;
        int dr;
        int dc;
        logic f;
        add_ctrl(REQ_DRAIN, REG_GRID_HEIGHT, '0);
        add_ctrl(REQ_CFG, REG_GRID_HEIGHT, h);
        add_ctrl(REQ_CFG, REG_GRID_WIDTH, w);
        plan_rows = h;
        plan_cols = w;
        eh = (clip_side(h) == 0) ? 2 : clip_side(h);
        ew = (clip_side(w) == 0) ? 2 : clip_side(w);
        calm_send = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            f = ($urandom_range(0, 99) < 35) ? FUNC_WRITE : FUNC_MARCH;
            if ($urandom_range(0, 9) == 0)
            begin
                sr = $urandom;
                sc = $urandom;
            end
            else
            begin
                sr = $urandom_range(0, eh - 1);
                sc = $urandom_range(0, ew - 1);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                dr = $urandom;
                dc = $urandom;
            end
            else
            begin
                dr = int'($urandom_range(0, 6)) - 3;
                dc = int'($urandom_range(0, 6)) - 3;
            end
            add_item(f, sr, sc, dr, dc, ($urandom_range(0, 3) != 0));
        end
    endtask

    // driver: presents requests and size writes, feeds the predictor on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        grid_req_t rq;
        logic      in_next;
        logic      cfg_next;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            cfg_valid <= 1'b0;
            gap_left   = 0;
            settle_cnt = 0;
            in_flight  = 0;
        end
        else
        begin
            in_next  = in_valid;
            cfg_next = cfg_valid;
            if (in_valid && !in_stall)
            begin
                rq.kind = REQ_ITEM;
                rq.f    = func;
                rq.sr   = start_row;
                rq.sc   = start_col;
                rq.dr   = dir_row;
                rq.dc   = dir_col;
                rq.blk  = blocked;
                end_cells_due.push_back(predict_end_cell(rq));
                in_flight++;
                in_next = 1'b0;
            end
            if (out_valid && !out_stall)
                in_flight--;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_GRID_HEIGHT)
                    rows_in_use = cfg_data;
                else
                    cols_in_use = cfg_data;
                cfg_next = 1'b0;
            end
            // pick the next request once nothing is held
            if (!in_next && !cfg_next)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (grid_reqs.size() > 0)
                begin
                    case (grid_reqs[0].kind)
                        REQ_ITEM:
                        begin
                            rq = grid_reqs.pop_front();
                            func      <= rq.f;
                            start_row <= rq.sr;
                            start_col <= rq.sc;
                            dir_row   <= rq.dr;
                            dir_col   <= rq.dc;
                            blocked   <= rq.blk;
                            in_next = 1'b1;
                            gap_left = rq.gap;
                        end
                        REQ_CFG:
                        begin
                            rq = grid_reqs.pop_front();
                            cfg_index <= rq.idx;
                            cfg_data  <= rq.data;
                            cfg_next = 1'b1;
                        end
                        default:
                        begin
                            // hold off until every result is back, then settle
                            if (in_flight != 0)
                                settle_cnt = 0;
                            else if (settle_cnt < SETTLE_CYCLES)
                                settle_cnt++;
                            else
                            begin
                                settle_cnt = 0;
                                void'(grid_reqs.pop_front());
                            end
                        end
                    endcase
                end
            end
            in_valid  <= in_next;
            cfg_valid <= cfg_next;
        end
    end

    // monitor: checks each result against the oldest expectation, draws stalls
    always @(posedge clk or negedge rst_n)
    begin
        end_cell_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (end_cells_due.size() == 0)
                    report_mismatch($sformatf("unexpected result (%0d,%0d)", end_row, end_col));
                else
                begin
                    want = end_cells_due.pop_front();
                    if (end_row !== want.row)
                        report_mismatch($sformatf("end_row %0d, expected %0d",
                                                  end_row, want.row));
                    if (end_col !== want.col)
                        report_mismatch($sformatf("end_col %0d, expected %0d",
                                                  end_col, want.col));
                end
                results_seen++;
                if (results_seen % 64 == 0)
                    calm_recv = ($urandom_range(0, 3) == 0);
                stall_left = calm_recv ? 0 : $urandom_range(0, 4);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // cycles without any accepted transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    // stimulus, reset and end of run
    initial
    begin
        // directed: corners, outside writes, blocked start, zero step, edges of fields
        add_item(FUNC_WRITE, 0, 0, 0, 0, 1'b1);
        add_item(FUNC_WRITE, 31, 31, -32, 31, 1'b1);
        add_item(FUNC_WRITE, 0, 31, 0, 0, 1'b1);
        add_item(FUNC_WRITE, 31, 0, 0, 0, 1'b1);
        add_item(FUNC_WRITE, 32, 0, 0, 0, 1'b1);
        add_item(FUNC_WRITE, -1, 5, 0, 0, 1'b1);
        add_item(FUNC_WRITE, 63, -64, 0, 0, 1'b1);
        add_item(FUNC_MARCH, 0, 0, 1, 1, 1'b0);
        add_item(FUNC_MARCH, -64, 63, 1, 1, 1'b1);
        add_item(FUNC_MARCH, 63, -64, -1, 1, 1'b0);
        add_item(FUNC_MARCH, 5, 5, 0, 0, 1'b0);
        add_item(FUNC_MARCH, 1, 1, -1, -1, 1'b0);
        add_item(FUNC_MARCH, 5, 5, 31, 31, 1'b0);
        add_item(FUNC_MARCH, 30, 30, -32, -32, 1'b1);
        add_item(FUNC_MARCH, 10, 0, 0, 1, 1'b0);
        add_item(FUNC_MARCH, 0, 5, 1, 0, 1'b0);
        add_item(FUNC_WRITE, 0, 0, 0, 0, 1'b0);
        add_item(FUNC_MARCH, 1, 1, -1, -1, 1'b0);
        add_item(FUNC_WRITE, 31, 5, 0, 0, 1'b1);
        add_item(FUNC_MARCH, 0, 5, 1, 0, 1'b0);
        add_item(FUNC_MARCH, 0, 30, 1, -1, 1'b0);
        add_item(FUNC_MARCH, 31, 1, -1, 1, 1'b0);

        // size settings including the extremes, then random ones, then back to full
        random_phase(6'd1, 6'd1);
        random_phase(6'd0, 6'd32);
        random_phase(6'd32, 6'd0);
        random_phase(6'd63, 6'd63);
        random_phase(6'd33, 6'd7);
        random_phase(6'd5, 6'd32);
        random_phase(6'd32, 6'd5);
        random_phase(6'd2, 6'd3);
        random_phase(6'd17, 6'd9);
        for (int i = 0; i < 3; i++)
            random_phase(SIZE_W'($urandom_range(1, 32)), SIZE_W'($urandom_range(1, 32)));
        random_phase(6'd32, 6'd32);
        random_phase(6'd32, 6'd32);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (!(grid_reqs.size() == 0 && !in_valid && !cfg_valid && in_flight == 0)
               && idle_cycles < IDLE_LIMIT)
            @(negedge clk);
        if (idle_cycles >= IDLE_LIMIT)
            $display("tb NOT OK");
        else
        begin
            repeat (TAIL_CYCLES) @(negedge clk);
            if (end_cells_due.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", end_cells_due.size()));
            if (fail_count == 0)
                $display("tb OK");
            else
                $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// File: grid_ray_march_to_obstacle_top.f
design/grmo_pkg.sv
design/grmo_ram.sv
design/grmo_ctrl.sv
design/grid_ray_march_to_obstacle_top.sv
tb/sv/tb.sv
